/* design/dwf_pkg.sv */
// ----------------------------------------------------------------------------
// dwf_pkg
// Shared constants, types and register indexes of the depth word converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dwf_pkg;

    localparam int QUOTIENT_BITS = 25;
    localparam int LZ_W          = $clog2(QUOTIENT_BITS + 1);
    localparam int WORD_W        = 32;
    localparam int SHIFT_W       = $clog2(WORD_W);
    localparam int MANT_W        = 23;
    localparam int EXP_W         = 8;
    localparam int CFG_IDX_W     = 1;

    localparam logic [WORD_W-1:0] FULL_MASK = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] LOW_MASK  = 32'h0000_ffff;
    localparam logic [WORD_W-1:0] ONE_BITS  = 32'h3f80_0000;
    localparam logic [EXP_W-1:0]  EXP_TOP   = 8'd126;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IS_32BIT = 1'b0,
        CFG_MASK     = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLS_FRAC = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_ONE  = 2'd2
    } cls_t;

    typedef struct packed {
        logic                     valid;
        cls_t                     cls;
        logic [WORD_W-1:0]        rem;
        logic [QUOTIENT_BITS-1:0] quo;
        logic [LZ_W-1:0]          lz;
    } cell_data_t;

endpackage

`default_nettype wire

/* design/depth_word_to_float.sv */
// throughput: one item per cycle while the skid stage is empty
// the row of 25 division cells computes one quotient bit each
// the skid stage keeps s_ready high while one result waits; it drops only when both are full
// reset: aresetn synchronous active low, clears valid bits and both format registers
// after reset the format is 16-bit words with the full-width field
// ----------------------------------------------------------------------------
// depth_word_to_float
// Converts a raw depth word into the single-precision bits of field / field max.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_word_to_float (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [dwf_pkg::WORD_W-1:0]       s_depth_word,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [dwf_pkg::WORD_W-1:0]            m_depth_float_bits,
    input  wire logic                             cfg_we,
    input  wire logic [dwf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dwf_pkg::WORD_W-1:0]       cfg_wdata
);

    logic                         adv;
    logic [dwf_pkg::WORD_W-1:0]   m_val;
    dwf_pkg::cell_data_t          chain [dwf_pkg::QUOTIENT_BITS+1];

    dwf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .s_valid      (s_valid),
        .s_depth_word (s_depth_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .head         (chain[0]),
        .m_val        (m_val)
    );

    for (genvar i = 0; i < dwf_pkg::QUOTIENT_BITS; i++) begin : g_cell
        dwf_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .m_val   (m_val),
            .d_in    (chain[i]),
            .d_out   (chain[i+1])
        );
    end

    dwf_out u_out (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .d_in               (chain[dwf_pkg::QUOTIENT_BITS]),
        .adv                (adv),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_depth_float_bits (m_depth_float_bits)
    );

    assign s_ready = adv;

endmodule

`default_nettype wire

/* design/dwf_front.sv */
// ----------------------------------------------------------------------------
// dwf_front
// Format registers, field extraction and alignment ahead of the divider row.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             adv,
    input  wire logic                             s_valid,
    input  wire logic [dwf_pkg::WORD_W-1:0]       s_depth_word,
    input  wire logic                             cfg_we,
    input  wire logic [dwf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dwf_pkg::WORD_W-1:0]       cfg_wdata,
    output dwf_pkg::cell_data_t                   head,
    output logic [dwf_pkg::WORD_W-1:0]            m_val
);

    logic                           is32_reg;
    logic [dwf_pkg::WORD_W-1:0]     mask_reg;
    logic [dwf_pkg::SHIFT_W-1:0]    tz_reg;
    logic [dwf_pkg::SHIFT_W-1:0]    tz_next;
    logic [dwf_pkg::WORD_W-1:0]     m_reg;
    logic [dwf_pkg::WORD_W-1:0]     width_mask;
    logic [dwf_pkg::WORD_W-1:0]     mask_eff;
    logic                           st0_valid_reg;
    logic [dwf_pkg::WORD_W-1:0]     field_reg;
    logic                           st1_valid_reg;
    logic [dwf_pkg::WORD_W-1:0]     q_reg;

    // format registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is32_reg <= 1'b0;
            mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (dwf_pkg::cfg_idx_t'(cfg_index))
                dwf_pkg::CFG_IS_32BIT: is32_reg <= cfg_wdata[0];
                dwf_pkg::CFG_MASK:     mask_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        width_mask = is32_reg ? dwf_pkg::FULL_MASK : dwf_pkg::LOW_MASK;
        mask_eff   = (mask_reg == '0) ? width_mask : mask_reg;
        tz_next    = '0;
        for (int i = dwf_pkg::WORD_W - 1; i >= 0; i--) begin
            if (mask_eff[i]) begin
                tz_next = dwf_pkg::SHIFT_W'(i);
            end
        end
    end

    // alignment and field maximum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tz_reg <= '0;
            m_reg  <= dwf_pkg::LOW_MASK;
        end else begin
            tz_reg <= tz_next;
            m_reg  <= mask_eff >> tz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
        end else if (adv) begin
            st0_valid_reg <= s_valid;
            st1_valid_reg <= st0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            field_reg <= s_depth_word & width_mask & mask_eff;
            q_reg     <= field_reg >> tz_reg;
        end
    end

    always_comb begin
        head.valid = st1_valid_reg;
        head.rem   = q_reg;
        head.quo   = '0;
        head.lz    = '0;
        priority if (q_reg == '0) begin
            head.cls = dwf_pkg::CLS_ZERO;
        end else if (q_reg >= m_reg) begin
            head.cls = dwf_pkg::CLS_ONE;
        end else begin
            head.cls = dwf_pkg::CLS_FRAC;
        end
    end

    assign m_val = m_reg;

endmodule

`default_nettype wire

/* design/dwf_cell.sv */
// ----------------------------------------------------------------------------
// dwf_cell
// One restoring division step with leading-zero tracking of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        adv,
    input  wire logic [dwf_pkg::WORD_W-1:0]  m_val,
    input  wire dwf_pkg::cell_data_t         d_in,
    output dwf_pkg::cell_data_t              d_out
);

    logic                         valid_reg;
    dwf_pkg::cell_data_t          data_reg;
    dwf_pkg::cell_data_t          data_next;
    logic [dwf_pkg::WORD_W:0]     rem2;
    logic [dwf_pkg::WORD_W:0]     diff;
    logic                         ge;
    logic                         seen;

    always_comb begin
        rem2            = {d_in.rem, 1'b0};
        diff            = rem2 - {1'b0, m_val};
        ge              = rem2 >= {1'b0, m_val};
        seen            = (d_in.quo != '0) || ge;
        data_next       = d_in;
        data_next.rem   = ge ? diff[dwf_pkg::WORD_W-1:0] : rem2[dwf_pkg::WORD_W-1:0];
        data_next.quo   = {d_in.quo[dwf_pkg::QUOTIENT_BITS-2:0], ge};
        data_next.lz    = seen ? d_in.lz : d_in.lz + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

/* design/dwf_out.sv */
// ----------------------------------------------------------------------------
// dwf_out
// Normalize and pack the quotient, output register with a skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dwf_pkg::cell_data_t         d_in,
    output logic                             adv,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [dwf_pkg::WORD_W-1:0]       m_depth_float_bits
);

    logic                                 out_valid_reg;
    logic [dwf_pkg::WORD_W-1:0]           out_reg;
    logic                                 skid_valid_reg;
    logic [dwf_pkg::WORD_W-1:0]           skid_reg;
    logic [dwf_pkg::WORD_W-1:0]           packed_bits;
    logic [dwf_pkg::QUOTIENT_BITS-1:0]    norm;
    logic [dwf_pkg::EXP_W-1:0]            expo;

    always_comb begin
        norm = d_in.quo << d_in.lz;
        expo = dwf_pkg::EXP_TOP - dwf_pkg::EXP_W'(d_in.lz);
        unique case (d_in.cls)
            dwf_pkg::CLS_ZERO: packed_bits = '0;
            dwf_pkg::CLS_ONE:  packed_bits = dwf_pkg::ONE_BITS;
            default: begin
                if (d_in.lz == dwf_pkg::LZ_W'(dwf_pkg::QUOTIENT_BITS)) begin
                    packed_bits = '0;
                end else begin
                    packed_bits = {1'b0, expo,
                                   norm[dwf_pkg::QUOTIENT_BITS-2 -: dwf_pkg::MANT_W]};
                end
            end
        endcase
    end

    assign adv = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (d_in.valid) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (d_in.valid) begin
            if (out_valid_reg && !m_ready) begin
                skid_reg <= packed_bits;
            end else begin
                out_reg <= packed_bits;
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_depth_float_bits = out_reg;

endmodule

`default_nettype wire

/* design/dwf_checker.sv */
// ----------------------------------------------------------------------------
// dwf_checker
// Port-level checks of the depth word converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [dwf_pkg::WORD_W-1:0]   m_depth_float_bits
);

    // no item shown right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("item shown after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_depth_float_bits))
        else $error("stalled item changed");

    // every result lies in [0, 1.0]
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_depth_float_bits <= dwf_pkg::ONE_BITS)
        else $error("result above 1.0");

    // input side stalls only while a result waits
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result waiting");

endmodule

bind depth_word_to_float dwf_checker u_dwf_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_depth_float_bits (m_depth_float_bits)
);

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_word_to_float testbench
// Streams raw depth words through the converter under a series of formats
// (16/32-bit words, zero, full, single-bit, sparse and random field masks)
// and checks every result against a bit-exact unorm-to-single predictor,
// with random idling on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------

module testbench;

    localparam int PHASES      = 13;
    localparam int RANDOM_ITEMS = 80;
    localparam int DRAIN_CYCLES = 40;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [31:0]         s_depth_word = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [31:0]         m_depth_float_bits;
    logic                cfg_we       = 1'b0;
    dwf_pkg::cfg_idx_t   cfg_index    = dwf_pkg::CFG_IS_32BIT;
    logic [31:0]         cfg_wdata    = '0;

    logic [31:0]    pending_words [$];
    logic [31:0]    expected_bits [$];
    logic           fmt_is32     = 1'b0;
    logic [31:0]    fmt_mask     = '0;
    bit             idle_enable  = 1'b1;
    int             gap_left     = 0;
    int             stall_left   = 0;
    int             error_count  = 0;

    logic           phase_is32 [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                                           1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [31:0]    phase_mask [PHASES] = '{32'h0, 32'h0, 32'hffff_0000, 32'h00ff_ff00,
                                            32'h8000_0000, 32'h1, 32'h0000_0ff0,
                                            32'hffff_ffff, 32'h0000_fff8, 32'ha5a5_0f0f,
                                            32'h3, 32'h0, 32'h0};
    logic [31:0]    edge_words [6] = '{32'h0, 32'h1, 32'h0000_ffff, 32'hffff_ffff,
                                       32'h8000_0000, 32'h0001_0000};

    depth_word_to_float i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_depth_word       (s_depth_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_depth_float_bits (m_depth_float_bits),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // field width and position after the zero-mask default
    function automatic logic [31:0] field_mask_of(input logic is32, input logic [31:0] mask);
        if (mask != 0) return mask;
        return is32 ? 32'hffff_ffff : 32'h0000_ffff;
    endfunction

    function automatic int low_zeros(input logic [31:0] mask);
        int n;
        n = 0;
        while (n < 31 && !mask[n]) n++;
        return n;
    endfunction

    function automatic logic [31:0] depth_to_float(input logic [31:0] word, input logic is32,
                                                   input logic [31:0] mask_cfg);
        logic [31:0] w;
        logic [31:0] msk;
        logic [31:0] field;
        logic [31:0] field_max;
        logic [63:0] rest;
        logic [31:0] quotient;
        logic [31:0] mant;
        logic [7:0]  expo;
        int          shift;
        int          msb;
        w         = is32 ? word : (word & 32'h0000_ffff);
        msk       = field_mask_of(is32, mask_cfg);
        shift     = low_zeros(msk);
        field     = (w & msk) >> shift;
        field_max = msk >> shift;
        if (field == 0 || field_max == 0) return 32'h0;
        if (field >= field_max) return 32'h3f80_0000;
        rest     = field;
        quotient = '0;
        for (int k = 0; k < dwf_pkg::QUOTIENT_BITS; k++) begin
            rest     = rest << 1;
            quotient = quotient << 1;
            if (rest >= {32'h0, field_max}) begin
                rest        = rest - field_max;
                quotient[0] = 1'b1;
            end
        end
        if (quotient == 0) return 32'h0;
        msb = 0;
        while (msb < 31 && (quotient >> (msb + 1)) != 0) msb++;
        mant = (msb >= 23) ? (quotient >> (msb - 23)) : (quotient << (23 - msb));
        expo = 8'(127 + msb - dwf_pkg::QUOTIENT_BITS);
        return {1'b0, expo, mant[22:0]};
    endfunction

    function automatic logic [31:0] pick_word(input logic is32, input logic [31:0] mask_cfg);
        logic [31:0] msk;
        logic [31:0] noise;
        int          shift;
        msk   = field_mask_of(is32, mask_cfg);
        shift = low_zeros(msk);
        noise = $urandom();
        unique case ($urandom_range(0, 5))
            0, 1: return noise;
            2:    return msk | (noise & ~msk);
            3:    return ($urandom_range(0, 255) << shift) | (noise & ~msk);
            4:    return (msk & ~(32'h1 << shift)) | (noise & ~msk);
            default: return (noise & msk) >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        error_count++;
    endtask

    task automatic write_format(input logic is32, input logic [31:0] mask);
        logic [31:0] junk;
        junk = $urandom();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= dwf_pkg::CFG_IS_32BIT;
        cfg_wdata <= {junk[31:1], is32};
        @(posedge aclk);
        cfg_index <= dwf_pkg::CFG_MASK;
        cfg_wdata <= mask;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        fmt_is32  = is32;
        fmt_mask  = mask;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || expected_bits.size() != 0)
            @(negedge aclk);
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_bits.push_back(depth_to_float(s_depth_word, fmt_is32, fmt_mask));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() != 0) begin
                    if (idle_enable && $urandom_range(0, 7) == 0) begin
                        s_valid  <= 1'b0;
                        gap_left <= $urandom_range(0, 10);
                    end else begin
                        s_valid      <= 1'b1;
                        s_depth_word <= pending_words.pop_front();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bits.size() == 0)
                    report_mismatch("unexpected item", m_depth_float_bits, 32'h0);
                else if (m_depth_float_bits !== expected_bits[0]) begin
                    report_mismatch("depth_float_bits", m_depth_float_bits, expected_bits[0]);
                    void'(expected_bits.pop_front());
                end else
                    void'(expected_bits.pop_front());
            end
            if (stall_left > 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 10);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] mask;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            mask = (p >= PHASES - 2) ? $urandom() : phase_mask[p];
            if (p > 0) begin
                wait_drained();
                repeat (DRAIN_CYCLES) @(negedge aclk);
                write_format(phase_is32[p], mask);
            end
            if (p == PHASES - 1) idle_enable = 1'b0;
            @(negedge aclk);
            if (p < 4)
                foreach (edge_words[i]) pending_words.push_back(edge_words[i]);
            repeat (RANDOM_ITEMS) pending_words.push_back(pick_word(fmt_is32, fmt_mask));
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("[depth_word_to_float] OK");
        else
            $display("[depth_word_to_float] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[depth_word_to_float] ERROR");
        $finish;
    end

endmodule
